// ----- rtl/core/fto_pkg.sv -----
// ----------------------------------------------------------------------------
// fto_pkg
// Types and constants shared by the flow timeout expiry core.
// ----------------------------------------------------------------------------
`default_nettype none

package fto_pkg;

  localparam int SLOT_W    = 10;
  localparam int KEY_W     = 64;
  localparam int TS_W      = 64;
  localparam int CNT_W     = 32;
  localparam int TO_W      = 16;
  localparam int US_W      = 20;
  localparam int TOUS_W    = TO_W + US_W;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 144;
  localparam int OUT_W     = 200;

  localparam logic [US_W-1:0]  US_PER_S = US_W'(1000000);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  typedef enum logic [1:0] {
    REASON_INACTIVE = 2'd0,
    REASON_ACTIVE   = 2'd1,
    REASON_END      = 2'd2
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 2'd0,
    CFG_INACTIVE = 2'd1,
    CFG_SUMMARY  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic take;
    logic diff;
    logic decide;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/fto_ram.sv -----
// ----------------------------------------------------------------------------
// fto_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/fto_ctrl.sv -----
// ----------------------------------------------------------------------------
// fto_ctrl
// Sequencer: clearing pass after reset, then read, difference, decision
// and commit steps for one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fto_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire fto_pkg::status_t status,
  output fto_pkg::cmd_t        cmd
);

  import fto_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/fto_dp.sv -----
// ----------------------------------------------------------------------------
// fto_dp
// Datapath: configuration, slot table, timeout tests, segment update and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fto_dp #(
  parameter int FLOW_SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fto_pkg::TO_W-1:0]      cfg_data,
  input  wire logic [fto_pkg::IN_W-1:0]      s_tdata,
  input  wire logic                          s_tuser,
  output logic      [fto_pkg::OUT_W-1:0]     m_tdata,
  output logic                               m_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire fto_pkg::cmd_t                 cmd,
  output fto_pkg::status_t                   status
);

  import fto_pkg::*;

  localparam int AW    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int ROW_W = 2 * TS_W + CNT_W;

  // configuration
  logic [TO_W-1:0]   act_secs;
  logic [TO_W-1:0]   inact_secs;
  logic              summary;
  logic [TOUS_W-1:0] active_us;
  logic [TOUS_W-1:0] inactive_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_secs   <= '0;
      inact_secs <= '0;
      summary    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACTIVE)   act_secs   <= cfg_data;
      if (cfg_index == CFG_INACTIVE) inact_secs <= cfg_data;
      if (cfg_index == CFG_SUMMARY)  summary    <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    active_us   <= TOUS_W'(act_secs) * TOUS_W'(US_PER_S);
    inactive_us <= TOUS_W'(inact_secs) * TOUS_W'(US_PER_S);
  end

  // clearing pass
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // captured beat
  logic             op;
  logic [AW-1:0]    slot_idx;
  logic             in_range;
  logic [KEY_W-1:0] key;
  logic [TS_W-1:0]  now;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op       <= s_tuser;
      slot_idx <= AW'(s_tdata[SLOT_W-1:0]);
      in_range <= (32'(s_tdata[SLOT_W-1:0]) < 32'(FLOW_SLOTS));
      key      <= s_tdata[SLOT_W +: KEY_W];
      now      <= s_tdata[SLOT_W+KEY_W +: TS_W];
    end
  end

  // slot table: {packets, last, start}
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] wrow;
  logic             wr_en;

  assign ram_we    = cmd.clear_step || (cmd.commit && wr_en);
  assign ram_waddr = cmd.clear_step ? clr_addr : slot_idx;
  assign ram_wdata = cmd.clear_step ? '0 : wrow;

  fto_ram #(
    .WIDTH (ROW_W),
    .DEPTH (FLOW_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  // differences
  logic [TS_W-1:0]  r_start;
  logic [TS_W-1:0]  r_last;
  logic [CNT_W-1:0] r_pkts;
  logic             r_empty;
  logic [TS_W-1:0]  eff_start;
  logic [TS_W-1:0]  eff_last;

  assign r_start   = ram_rdata[0 +: TS_W];
  assign r_last    = ram_rdata[TS_W +: TS_W];
  assign r_pkts    = ram_rdata[2*TS_W +: CNT_W];
  assign r_empty   = (r_pkts == '0);
  assign eff_start = r_empty ? now : r_start;
  assign eff_last  = r_empty ? now : r_last;

  logic [TS_W-1:0]  seg_start;
  logic [TS_W-1:0]  seg_last;
  logic [CNT_W-1:0] seg_pkts;
  logic             empty;
  logic [TS_W-1:0]  dur;
  logic [TS_W-1:0]  d_last;
  logic [TS_W-1:0]  d_start;
  logic             gt_last;
  logic             gt_start;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      seg_start <= r_start;
      seg_last  <= r_last;
      seg_pkts  <= r_pkts;
      empty     <= r_empty;
      dur       <= r_last - r_start;
      d_last    <= now - eff_last;
      d_start   <= now - eff_start;
      gt_last   <= (now > eff_last);
      gt_start  <= (now > eff_start);
    end
  end

  // decision
  logic       fire_in;
  logic       fire_act;
  logic       close_c;
  logic       we_c;
  reason_t    reason_c;
  logic [ROW_W-1:0] wrow_c;
  logic [CNT_W-1:0] pkts_inc;

  assign fire_in  = (inactive_us != '0) && gt_last && (d_last > TS_W'(inactive_us));
  assign fire_act = (active_us != '0) && gt_start && (d_start > TS_W'(active_us));
  assign pkts_inc = (seg_pkts == CNT_MAX) ? CNT_MAX : seg_pkts + CNT_W'(1);

  always_comb begin
    close_c  = 1'b0;
    we_c     = 1'b0;
    reason_c = REASON_END;
    wrow_c   = {seg_pkts, seg_last, seg_start};
    if (in_range) begin
      if (op) begin
        close_c = !empty;
        we_c    = !empty;
        wrow_c  = {CNT_W'(0), seg_last, seg_start};
      end else begin
        we_c = 1'b1;
        if (fire_in || fire_act) begin
          close_c  = 1'b1;
          reason_c = fire_in ? REASON_INACTIVE : REASON_ACTIVE;
          wrow_c   = {CNT_W'(1), now, now};
        end else begin
          wrow_c = {pkts_inc, now, empty ? now : seg_start};
        end
      end
    end
  end

  logic    close_q;
  reason_t reason_q;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      close_q  <= close_c;
      reason_q <= reason_c;
      wr_en    <= we_c;
      wrow     <= wrow_c;
    end
  end

  // flow counter and result register
  logic [CNT_W-1:0] closed_total;
  logic [CNT_W-1:0] total_next;
  logic             rec;

  assign total_next = (close_q && closed_total != CNT_MAX) ? closed_total + CNT_W'(1)
                                                           : closed_total;
  assign rec        = close_q && !summary;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_total <= '0;
    end else if (cmd.commit) begin
      closed_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= rec;
      m_tdata <= {6'b0,
                  total_next,
                  rec ? reason_q : REASON_INACTIVE,
                  rec ? seg_pkts : CNT_W'(0),
                  rec ? dur      : TS_W'(0),
                  rec ? key      : KEY_W'(0)};
    end
  end

  assign status.out_free   = !m_tvalid || m_tready;
  assign status.clear_done = (clr_addr == AW'(FLOW_SLOTS - 1));

endmodule

`default_nettype wire

// ----- rtl/core/flow_timeout_expiry_core.sv -----
// ----------------------------------------------------------------------------
// flow_timeout_expiry_core
// Flow table expiry with active and inactive timeouts, one result per beat.
// ----------------------------------------------------------------------------
// The beat is taken, then passes through slot table read, difference, decision
// and commit before the result register is loaded; no new beat is accepted
// until commit, which waits while the result register is held by m_tready.
// Reset: a clearing pass empties every slot table row; s_tready stays low
// until it ends. Configuration resets to zero.
`default_nettype none

module flow_timeout_expiry_core #(
  parameter int FLOW_SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fto_pkg::TO_W-1:0]      cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [fto_pkg::IN_W-1:0]      s_tdata,  // flow_slot, flow_key, timestamp_us
  input  wire logic                          s_tuser,  // opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [fto_pkg::OUT_W-1:0]     m_tdata,  // record_key, duration_us,
                                                       // packet_count, expiry_reason,
                                                       // flows_total
  output logic                               m_tuser   // record_valid
);

  import fto_pkg::*;

  cmd_t    cmd;
  status_t status;

  fto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fto_dp #(
    .FLOW_SLOTS (FLOW_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow timeout expiry core. A directed table runs
// through the timeout edges, backward time, flush of empty and full slots,
// summary mode and the widest timeouts. Random phases then drive packet
// sequences on a small pool of slots under several register settings. Every
// result beat is checked against the table row or an in-bench flow table model.
// ----------------------------------------------------------------------------

module tb_top;
  import fto_pkg::*;

  localparam int          NUM_SLOTS   = 1024;
  localparam int          LIMIT       = 300000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic        OP_PACKET   = 1'b0;
  localparam logic        OP_FLUSH    = 1'b1;
  localparam int          SLOT_LO     = 0;
  localparam int          KEY_LO      = SLOT_LO + SLOT_W;
  localparam int          TS_LO       = KEY_LO + KEY_W;
  localparam int          RK_LO       = 0;
  localparam int          DUR_LO      = RK_LO + KEY_W;
  localparam int          PK_LO       = DUR_LO + TS_W;
  localparam int          RS_LO       = PK_LO + CNT_W;
  localparam int          TOT_LO      = RS_LO + 2;
  localparam logic [63:0] K_A         = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] K_B         = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] K_C         = 64'h5a5a_a5a5_0f0f_f0f0;
  localparam logic [63:0] K_D         = 64'h8000_0000_0000_0001;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic             rec_valid;
    logic [KEY_W-1:0] key;
    logic [TS_W-1:0]  dur;
    logic [CNT_W-1:0] pkts;
    reason_t          why;
    logic [CNT_W-1:0] total;
  } flow_rec_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_t         idx;
    logic [TO_W-1:0]  val;
    logic             op;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0] fkey;
    logic [TS_W-1:0]  ts;
    bit               typed;
    flow_rec_t        want;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TO_W-1:0]   cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;

  // flow table model
  logic [TS_W-1:0]   slot_start [NUM_SLOTS];
  logic [TS_W-1:0]   slot_last  [NUM_SLOTS];
  logic [CNT_W-1:0]  slot_pkts  [NUM_SLOTS];
  logic [CNT_W-1:0]  flows_closed;
  logic [TO_W-1:0]   act_to_s;
  logic [TO_W-1:0]   inact_to_s;
  logic              summ_en;

  flow_rec_t         pending_recs [$];
  dir_row_t          dir_rows [$];
  flow_rec_t         seen_rec;
  flow_rec_t         want_rec;
  flow_rec_t         no_rec;

  rx_mode_t          rx_mode = RX_ALWAYS;
  int                hold_reqs = 0;
  int                holds_seen = 0;
  int                hold_left = 0;
  int                rx_tick = 0;
  int                cyc_cnt = 0;
  int                mismatches = 0;
  int                burst_left = 1;
  bit                steady = 0;
  int                n_pkt = 0;
  int                n_flush = 0;
  int                n_recs = 0;
  int                n_settings = 0;
  logic [TS_W-1:0]   now_us = '0;

  flow_timeout_expiry_core #(
    .FLOW_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // flow_slot, flow_key, timestamp_us
    .s_tuser  (s_tuser),  // opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),  // record_key, duration_us, packet_count, expiry_reason,
                          // flows_total
    .m_tuser  (m_tuser)   // record_valid
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cyc_cnt,
               pending_recs.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic flow_rec_t blank_rec();
    flow_rec_t r;
    r.rec_valid = 1'b0;
    r.key       = '0;
    r.dur       = '0;
    r.pkts      = '0;
    r.why       = REASON_INACTIVE;
    r.total     = '0;
    return r;
  endfunction

  function automatic bit over_limit(logic [TS_W-1:0] last, logic [TS_W-1:0] now,
                                    logic [TS_W-1:0] lim);
    if (lim == '0 || now <= last)
      return 1'b0;
    return (now - last) > lim;
  endfunction

  function automatic flow_rec_t close_seg(logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] fkey,
                                          reason_t why);
    flow_rec_t r;
    r = blank_rec();
    if (flows_closed != CNT_MAX)
      flows_closed++;
    if (!summ_en) begin
      r.rec_valid = 1'b1;
      r.key       = fkey;
      r.dur       = slot_last[slot] - slot_start[slot];
      r.pkts      = slot_pkts[slot];
      r.why       = why;
    end
    return r;
  endfunction

  function automatic flow_rec_t expire_step(logic op, logic [SLOT_W-1:0] slot,
                                            logic [KEY_W-1:0] fkey, logic [TS_W-1:0] ts);
    flow_rec_t r;
    logic [TS_W-1:0] act_lim;
    logic [TS_W-1:0] inact_lim;
    bit fired;
    r = blank_rec();
    fired = 1'b0;
    act_lim   = TS_W'(act_to_s) * TS_W'(US_PER_S);
    inact_lim = TS_W'(inact_to_s) * TS_W'(US_PER_S);
    if (op == OP_FLUSH) begin
      if (slot_pkts[slot] != '0) begin
        r = close_seg(slot, fkey, REASON_END);
        slot_pkts[slot] = '0;
      end
    end else begin
      if (slot_pkts[slot] == '0) begin
        slot_start[slot] = ts;
        slot_last[slot]  = ts;
      end
      if (over_limit(slot_last[slot], ts, inact_lim)) begin
        r = close_seg(slot, fkey, REASON_INACTIVE);
        fired = 1'b1;
      end else if (over_limit(slot_start[slot], ts, act_lim)) begin
        r = close_seg(slot, fkey, REASON_ACTIVE);
        fired = 1'b1;
      end
      if (fired) begin
        slot_start[slot] = ts;
        slot_last[slot]  = ts;
        slot_pkts[slot]  = 1;
      end else begin
        if (slot_pkts[slot] != CNT_MAX)
          slot_pkts[slot]++;
        slot_last[slot] = ts;
      end
    end
    r.total = flows_closed;
    return r;
  endfunction

  task automatic note_fail(string what, flow_rec_t want, flow_rec_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp v=%0d key=%h dur=%h pkts=%0d why=%0d tot=%0d", $realtime, what,
               want.rec_valid, want.key, want.dur, want.pkts, want.why, want.total);
      $display("    got v=%0d key=%h dur=%h pkts=%0d why=%0d tot=%0d", got.rec_valid,
               got.key, got.dur, got.pkts, got.why, got.total);
    end
  endtask

  // result beats
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_rec.rec_valid = m_tuser;
      seen_rec.key       = m_tdata[RK_LO +: KEY_W];
      seen_rec.dur       = m_tdata[DUR_LO +: TS_W];
      seen_rec.pkts      = m_tdata[PK_LO +: CNT_W];
      seen_rec.why       = reason_t'(m_tdata[RS_LO +: 2]);
      seen_rec.total     = m_tdata[TOT_LO +: CNT_W];
      if (m_tuser === 1'b1)
        n_recs++;
      if (pending_recs.size() == 0) begin
        note_fail("unexpected beat", no_rec, seen_rec);
      end else begin
        want_rec = pending_recs.pop_front();
        if (seen_rec.rec_valid !== want_rec.rec_valid || seen_rec.key !== want_rec.key ||
            seen_rec.dur !== want_rec.dur || seen_rec.pkts !== want_rec.pkts ||
            seen_rec.why !== want_rec.why || seen_rec.total !== want_rec.total)
          note_fail("mismatch", want_rec, seen_rec);
      end
    end
  end

  // receiver: own stall pattern plus requested long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_tready = 1'b1;
          RX_RANDOM: m_tready = ($urandom_range(3) != 0);
          default:   m_tready = ((rx_tick % 11) >= 4);
        endcase
      end
    end
  end

  task automatic send_beat(logic op, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] fkey,
                           logic [TS_W-1:0] ts, bit typed, flow_rec_t typed_rec);
    flow_rec_t r;
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = '0;
    s_tdata[SLOT_LO +: SLOT_W] = slot;
    s_tdata[KEY_LO +: KEY_W]   = fkey;
    s_tdata[TS_LO +: TS_W]     = ts;
    do @(posedge clk); while (!s_tready);
    r = expire_step(op, slot, fkey, ts);
    pending_recs.insert(pending_recs.size(), typed ? typed_rec : r);
    if (op == OP_FLUSH)
      n_flush++;
    else
      n_pkt++;
    if (!steady) begin
      if (burst_left > 0)
        burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(8, 1);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(16, 1);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_recs.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = $urandom_range(16, 1);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [TO_W-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_ACTIVE:   act_to_s   = val;
      CFG_INACTIVE: inact_to_s = val;
      CFG_SUMMARY:  summ_en    = val[0];
      default: ;
    endcase
  endtask

  function automatic dir_row_t item_row(logic op, logic [SLOT_W-1:0] slot,
                                        logic [KEY_W-1:0] fkey, logic [TS_W-1:0] ts);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.idx    = CFG_ACTIVE;
    d.val    = '0;
    d.op     = op;
    d.slot   = slot;
    d.fkey   = fkey;
    d.ts     = ts;
    d.typed  = 1'b0;
    d.want   = blank_rec();
    return d;
  endfunction

  function automatic dir_row_t chk_row(logic op, logic [SLOT_W-1:0] slot,
                                       logic [KEY_W-1:0] fkey, logic [TS_W-1:0] ts,
                                       logic v, logic [TS_W-1:0] dur, logic [CNT_W-1:0] pkts,
                                       reason_t why, logic [CNT_W-1:0] total);
    dir_row_t d;
    d = item_row(op, slot, fkey, ts);
    d.typed          = 1'b1;
    d.want.rec_valid = v;
    d.want.key       = v ? fkey : '0;
    d.want.dur       = dur;
    d.want.pkts      = pkts;
    d.want.why       = why;
    d.want.total     = total;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t idx, logic [TO_W-1:0] val);
    dir_row_t d;
    d = item_row(OP_PACKET, '0, '0, '0);
    d.is_cfg = 1'b1;
    d.idx    = idx;
    d.val    = val;
    return d;
  endfunction

  function automatic void add_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  task automatic run_phase(logic [TO_W-1:0] act, logic [TO_W-1:0] inact, logic summ,
                           int count, bit no_idle, bit with_hold, rx_mode_t mode);
    logic [SLOT_W-1:0] pool [6];
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  fkey;
    logic [TS_W-1:0]   ts;
    logic              op;
    int                pick;
    set_reg(CFG_ACTIVE, act);
    set_reg(CFG_INACTIVE, inact);
    set_reg(CFG_SUMMARY, {{(TO_W-1){1'b0}}, summ});
    n_settings++;
    steady  = no_idle;
    rx_mode = mode;
    foreach (pool[i])
      pool[i] = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 15)
        hold_reqs++;
      slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(NUM_SLOTS - 1))
                                      : pool[$urandom_range(5)];
      fkey = {$urandom, $urandom};
      op   = ($urandom_range(99) < 8) ? OP_FLUSH : OP_PACKET;
      if (op == OP_FLUSH) begin
        ts = {$urandom, $urandom};
      end else begin
        pick = $urandom_range(99);
        if (pick < 65)
          now_us = now_us + $urandom_range(400000);
        else if (pick < 85)
          now_us = now_us + $urandom_range(3500000, 900000);
        else if (pick < 92)
          now_us = now_us + {32'($urandom_range(40)), $urandom};
        else if (pick < 96)
          now_us = now_us - $urandom_range(2000000);
        else
          now_us = {$urandom, $urandom};
        ts = now_us;
      end
      send_beat(op, slot, fkey, ts, 1'b0, no_rec);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    no_rec    = blank_rec();
    flows_closed = '0;
    act_to_s     = '0;
    inact_to_s   = '0;
    summ_en      = 1'b0;
    foreach (slot_pkts[i]) begin
      slot_start[i] = '0;
      slot_last[i]  = '0;
      slot_pkts[i]  = '0;
    end

    add_row(cfg_row(CFG_ACTIVE, 16'd2));
    add_row(cfg_row(CFG_INACTIVE, 16'd1));
    add_row(cfg_row(CFG_SUMMARY, 16'd0));
    add_row(chk_row(OP_FLUSH, 0, K_A, 0, 0, 0, 0, REASON_INACTIVE, 0));
    add_row(chk_row(OP_PACKET, 0, K_A, 0, 0, 0, 0, REASON_INACTIVE, 0));
    add_row(chk_row(OP_PACKET, 0, K_A, 64'd1_000_000, 0, 0, 0, REASON_INACTIVE, 0));
    add_row(chk_row(OP_PACKET, 0, K_A, 64'd2_000_000, 0, 0, 0, REASON_INACTIVE, 0));
    add_row(chk_row(OP_PACKET, 0, K_A, 64'd2_000_001, 1, 64'd2_000_000, 3,
                    REASON_ACTIVE, 1));
    add_row(chk_row(OP_PACKET, 0, K_B, 64'd3_000_002, 1, 0, 1, REASON_INACTIVE, 2));
    // time going backward
    add_row(item_row(OP_PACKET, 0, K_B, 64'd5));
    add_row(item_row(OP_FLUSH, 0, K_B, '1));
    add_row(chk_row(OP_FLUSH, 0, K_B, 0, 0, 0, 0, REASON_INACTIVE, 3));
    add_row(chk_row(OP_PACKET, 1023, '1, '1, 0, 0, 0, REASON_INACTIVE, 3));
    add_row(item_row(OP_PACKET, 1023, '1, '0));
    add_row(chk_row(OP_FLUSH, 1023, '1, '1, 1, 64'd1, 2, REASON_END, 4));
    add_row(cfg_row(CFG_SUMMARY, 16'd1));
    add_row(item_row(OP_PACKET, 5, K_C, 64'd100));
    add_row(chk_row(OP_FLUSH, 5, K_C, 0, 0, 0, 0, REASON_INACTIVE, 5));
    add_row(cfg_row(CFG_SUMMARY, 16'd0));
    add_row(cfg_row(CFG_ACTIVE, 16'hffff));
    add_row(cfg_row(CFG_INACTIVE, 16'hffff));
    add_row(item_row(OP_PACKET, 7, K_D, 0));
    add_row(chk_row(OP_PACKET, 7, K_D, 64'd65_535_000_001, 1, 0, 1,
                    REASON_INACTIVE, 6));
    add_row(item_row(OP_PACKET, 7, K_D, 64'd131_070_000_002));
    add_row(cfg_row(CFG_INACTIVE, 16'd0));
    add_row(item_row(OP_PACKET, 7, K_D, 64'd196_605_000_003));
    add_row(cfg_row(CFG_ACTIVE, 16'd1));
    add_row(item_row(OP_PACKET, 8, K_A, 64'd10));
    add_row(item_row(OP_PACKET, 8, K_A, 64'd500_010));
    add_row(item_row(OP_PACKET, 8, K_A, 64'd1_000_011));

    repeat (3) @(negedge clk);
    rst = 1'b0;
    // table clear runs after reset
    while (!s_tready)
      @(posedge clk);

    rx_mode = RX_RANDOM;
    n_settings++;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_beat(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].fkey, dir_rows[i].ts,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    run_phase(16'd0, 16'd0, 1'b0, 80, 1'b0, 1'b0, RX_PATTERN);
    run_phase(16'd1, 16'd1, 1'b0, 90, 1'b0, 1'b1, RX_RANDOM);
    run_phase(16'd2, 16'd1, 1'b0, 90, 1'b1, 1'b0, RX_ALWAYS);
    run_phase(16'hffff, 16'hffff, 1'b0, 80, 1'b0, 1'b0, RX_PATTERN);
    run_phase(16'd1, 16'd0, 1'b1, 80, 1'b0, 1'b0, RX_RANDOM);
    run_phase(16'd0, 16'd2, 1'b0, 90, 1'b0, 1'b0, RX_ALWAYS);
    run_phase(16'd3, 16'hffff, 1'b0, 90, 1'b0, 1'b1, RX_PATTERN);

    drain_results();
    repeat (10) @(negedge clk);
    $display("Ran %0d packet and %0d flush beats under %0d register settings", n_pkt,
             n_flush, n_settings);
    $display("%0d records emitted, %0d flows closed, %0d mismatches", n_recs, flows_closed,
             mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
